// ===== rtl/ils_pkg.sv =====
// ils_pkg: shared constants, codes and types for the indexed list store.
// Used by ils_pos_resolve and indexed_list_store_top; depends on nothing.
`default_nettype none

package ils_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int KIND_W   = 3;
    localparam int STAT_W   = 2;
    // width that holds both a position magnitude and the entry count
    localparam int RW       = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIND   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    localparam logic [POS_W-1:0] POS_NONE = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_REMOVE,
        ST_FIND
    } ils_state_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] where;
    } ils_pos_t;

endpackage

`default_nettype wire

// ===== rtl/indexed_list_store_top.sv =====
// indexed_list_store_top: bounded list of 32-bit words with append, indexed
// remove and read, linear find and clear. Depends on ils_pkg, ils_pos_resolve.
//
// A request is taken when start is high and busy is low; its result appears
// for one cycle with done high, and the receiver cannot stall it. Entries sit
// in a 16-word memory with one write and one registered read port, and remove
// and find walk it one entry per cycle. Append, clear, unused kinds and
// rejected requests give done on the next cycle and never raise busy. Read
// holds busy for its registered memory read. Remove holds busy while later
// entries shift down; find holds busy until the first match or the end of
// the list. busy falls in the cycle done rises, so a new request may be
// issued against the strobe.
`default_nettype none

module indexed_list_store_top
    import ils_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic        [KIND_W-1:0] kind,
    input  wire logic signed [POS_W-1:0]  position_arg,
    input  wire logic signed [VAL_W-1:0]  value_arg,
    output logic                          busy,
    output logic                          done,
    output logic             [STAT_W-1:0] status,
    output logic signed      [VAL_W-1:0]  read_value,
    output logic signed      [POS_W-1:0]  found_position,
    output logic             [POS_W-1:0]  entry_count
);

    ils_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  paddr_reg, paddr_next;
    logic [VAL_W-1:0]  key_reg, key_next;
    logic              done_reg, done_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [VAL_W-1:0]  rval_reg, rval_next;
    logic [POS_W-1:0]  found_reg, found_next;
    logic [VAL_W-1:0]  rdata_reg;

    logic [VAL_W-1:0]  mem [CAPACITY];
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [VAL_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;

    ils_pos_t          pos;
    logic              accept;
    logic              last;
    logic              hit;

    ils_pos_resolve u_pos
    (
        .position (position_arg),
        .count    (count_reg),
        .res      (pos)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign last   = (ptr_reg >= count_reg);
    // compare unit for find
    assign hit    = pend_reg && (rdata_reg == key_reg);

    assign done           = done_reg;
    assign status         = status_reg;
    assign read_value     = rval_reg;
    assign found_position = found_reg;
    assign entry_count    = POS_W'(count_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        KIND_REMOVE: if (pos.valid) state_next = ST_REMOVE;
                        KIND_READ:   if (pos.valid) state_next = ST_READ;
                        KIND_FIND:   state_next = ST_FIND;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:   state_next = ST_IDLE;
            ST_REMOVE: if (last) state_next = ST_IDLE;
            ST_FIND:   if (hit || last) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        pend_next   = pend_reg;
        paddr_next  = paddr_reg;
        key_next    = key_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        rval_next   = rval_reg;
        found_next  = found_reg;
        mem_we      = 1'b0;
        mem_waddr   = IDX_W'(count_reg);
        mem_wdata   = value_arg;
        mem_re      = 1'b0;
        mem_raddr   = pos.where;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next    = value_arg;
                    status_next = STAT_OK;
                    rval_next   = '0;
                    found_next  = '0;
                    pend_next   = 1'b0;
                    unique case (kind)
                        KIND_APPEND:
                        begin
                            done_next = 1'b1;
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = CNT_W'(count_reg + 1'b1);
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (!pos.valid)
                            begin
                                status_next = STAT_RANGE;
                                done_next   = 1'b1;
                            end
                            ptr_next = CNT_W'(CNT_W'(pos.where) + 1'b1);
                        end
                        KIND_READ:
                        begin
                            if (!pos.valid)
                            begin
                                status_next = STAT_RANGE;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                mem_re = 1'b1;
                            end
                        end
                        KIND_FIND:
                        begin
                            ptr_next   = '0;
                            found_next = POS_NONE;
                        end
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        default: done_next = 1'b1;
                    endcase
                end
            end
            ST_READ:
            begin
                rval_next = rdata_reg;
                done_next = 1'b1;
            end
            ST_REMOVE:
            begin
                // entry read last cycle moves down one slot
                mem_we    = pend_reg;
                mem_waddr = IDX_W'(paddr_reg - 1'b1);
                mem_wdata = rdata_reg;
                if (!last)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = IDX_W'(ptr_reg);
                    pend_next  = 1'b1;
                    paddr_next = IDX_W'(ptr_reg);
                    ptr_next   = CNT_W'(ptr_reg + 1'b1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    count_next = CNT_W'(count_reg - 1'b1);
                    done_next  = 1'b1;
                end
            end
            ST_FIND:
            begin
                if (hit)
                begin
                    found_next = POS_W'(paddr_reg);
                    pend_next  = 1'b0;
                    done_next  = 1'b1;
                end
                else if (last)
                begin
                    pend_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = IDX_W'(ptr_reg);
                    pend_next  = 1'b1;
                    paddr_next = IDX_W'(ptr_reg);
                    ptr_next   = CNT_W'(ptr_reg + 1'b1);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        paddr_reg  <= paddr_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        rval_reg   <= rval_next;
        found_reg  <= found_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy) || $past(accept))
        else $error("done without a request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_count_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> done_reg)
        else $error("entry count changed without a result");

    a_hit_ends_find: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIND && hit) |=> done_reg && state_reg == ST_IDLE)
        else $error("find did not stop at match");

    a_remove_write_below: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REMOVE && mem_we) |-> CNT_W'(mem_waddr) < count_reg)
        else $error("remove shift writes past the list end");

endmodule

`default_nettype wire

// ===== rtl/ils_pos_resolve.sv =====
// ils_pos_resolve: maps a signed position onto an entry index and checks
// it against the current entry count. Depends on ils_pkg.
`default_nettype none

module ils_pos_resolve
    import ils_pkg::*;
(
    input  wire logic signed [POS_W-1:0] position,
    input  wire logic        [CNT_W-1:0] count,
    output ils_pos_t                     res
);

    logic [RW-1:0] bits_w;
    logic [RW-1:0] cnt_w;
    logic [RW-1:0] back_w;

    assign bits_w = RW'(unsigned'(position));
    assign cnt_w  = RW'(count);
    assign back_w = RW'(1 << POS_W) - bits_w;

    always_comb
    begin
        if (position[POS_W-1])
        begin
            res.valid = (back_w <= cnt_w);
            res.where = IDX_W'(cnt_w - back_w);
        end
        else
        begin
            res.valid = (bits_w < cnt_w);
            res.where = IDX_W'(bits_w);
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for indexed_list_store_top.
// Depends on ils_pkg and the RTL; runs directed then random list requests and
// checks every result against an in-bench model of the list.
`timescale 1ns / 100ps

module tb_top
    import ils_pkg::*;
();

    typedef struct {
        logic [KIND_W-1:0]       kind;
        logic signed [POS_W-1:0] pos;
        logic signed [VAL_W-1:0] val;
        int unsigned             gap;
        bit                      drain_first;
    } list_request_t;

    typedef struct {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] read_value;
        logic signed [POS_W-1:0] found_position;
        logic [POS_W-1:0]        entry_count;
    } list_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic [KIND_W-1:0]        kind;
    logic signed [POS_W-1:0]  position_arg;
    logic signed [VAL_W-1:0]  value_arg;
    logic                     busy;
    logic                     done;
    logic [STAT_W-1:0]        status;
    logic signed [VAL_W-1:0]  read_value;
    logic signed [POS_W-1:0]  found_position;
    logic [POS_W-1:0]         entry_count;

    list_request_t   pending_requests[$];
    list_result_t    expected_results[$];
    logic [VAL_W-1:0] list_words[CAPACITY];
    int              list_len;
    int              error_count;
    logic            req_taken;
    int unsigned     gap_left;
    bit              gap_armed;
    list_result_t    got_result;
    list_result_t    want_result;
    logic [VAL_W-1:0] value_pool[8];

    indexed_list_store_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .kind           (kind),
        .position_arg   (position_arg),
        .value_arg      (value_arg),
        .busy           (busy),
        .done           (done),
        .status         (status),
        .read_value     (read_value),
        .found_position (found_position),
        .entry_count    (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Applies one request to the list model and returns the result it must give.
    function automatic list_result_t apply_list_request(input logic [KIND_W-1:0] k,
                                                       input logic signed [POS_W-1:0] p,
                                                       input logic signed [VAL_W-1:0] v);
        list_result_t r;
        int           where;
        bit           in_range;
        int           i;
        r.status         = STAT_OK;
        r.read_value     = '0;
        r.found_position = '0;
        in_range         = 1'b0;
        where            = 0;
        if (p < 0)
        begin
            if (-int'(p) <= list_len)
            begin
                in_range = 1'b1;
                where    = list_len + int'(p);
            end
        end
        else if (int'(p) < list_len)
        begin
            in_range = 1'b1;
            where    = int'(p);
        end
        case (k)
            KIND_APPEND:
            begin
                if (list_len >= CAPACITY)
                    r.status = STAT_FULL;
                else
                begin
                    list_words[list_len] = v;
                    list_len++;
                end
            end
            KIND_REMOVE:
            begin
                if (!in_range)
                    r.status = STAT_RANGE;
                else
                begin
                    for (i = where; i < list_len - 1; i++)
                        list_words[i] = list_words[i + 1];
                    list_len--;
                end
            end
            KIND_READ:
            begin
                if (!in_range)
                    r.status = STAT_RANGE;
                else
                    r.read_value = list_words[where];
            end
            KIND_FIND:
            begin
                r.found_position = POS_NONE;
                for (i = 0; i < list_len; i++)
                begin
                    if (list_words[i] == v)
                    begin
                        r.found_position = i[POS_W-1:0];
                        break;
                    end
                end
            end
            KIND_CLEAR:
                list_len = 0;
            default:
                ;
        endcase
        r.entry_count = list_len[POS_W-1:0];
        return r;
    endfunction

    task automatic queue_request(input logic [KIND_W-1:0] k, input logic signed [POS_W-1:0] p,
                                 input logic signed [VAL_W-1:0] v, input bit no_idle,
                                 input bit drain_first);
        list_request_t req;
        req.kind        = k;
        req.pos         = p;
        req.val         = v;
        req.gap         = no_idle ? 0 : $urandom_range(0, 4);
        req.drain_first = drain_first;
        pending_requests.push_back(req);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 60)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic signed [POS_W-1:0] pick_position();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return POS_W'($urandom_range(0, 31));
        if (r < 70)
            return POS_W'($urandom_range(0, 15));
        return POS_W'(-$urandom_range(1, 16));
    endfunction

    // Driver: presents requests at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!start || req_taken)
            begin
                if (pending_requests.size() == 0)
                    start <= 1'b0;
                else
                begin
                    if (!gap_armed)
                    begin
                        gap_left  = pending_requests[0].gap;
                        gap_armed = 1'b1;
                    end
                    if (gap_left > 0 ||
                        (pending_requests[0].drain_first && expected_results.size() != 0))
                    begin
                        start <= 1'b0;
                        if (gap_left > 0)
                            gap_left--;
                    end
                    else
                    begin
                        start        <= 1'b1;
                        kind         <= pending_requests[0].kind;
                        position_arg <= pending_requests[0].pos;
                        value_arg    <= pending_requests[0].val;
                        void'(pending_requests.pop_front());
                        gap_armed = 1'b0;
                    end
                end
            end
        end
    end

    // Monitor: checks results and predicts each accepted request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_taken <= 1'b0;
        else
        begin
            req_taken <= start && !busy;
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with no request pending", VAL_W'(status), '0);
                else
                begin
                    want_result               = expected_results.pop_front();
                    got_result.status         = status;
                    got_result.read_value     = read_value;
                    got_result.found_position = found_position;
                    got_result.entry_count    = entry_count;
                    if (got_result.status !== want_result.status)
                        report_mismatch("status", VAL_W'(got_result.status),
                                        VAL_W'(want_result.status));
                    if (got_result.read_value !== want_result.read_value)
                        report_mismatch("read_value", got_result.read_value,
                                        want_result.read_value);
                    if (got_result.found_position !== want_result.found_position)
                        report_mismatch("found_position", VAL_W'(got_result.found_position),
                                        VAL_W'(want_result.found_position));
                    if (got_result.entry_count !== want_result.entry_count)
                        report_mismatch("entry_count", VAL_W'(got_result.entry_count),
                                        VAL_W'(want_result.entry_count));
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_list_request(kind, position_arg, value_arg));
        end
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int          blk;
        int          n;
        int          mode;
        int unsigned r;
        bit          no_idle;
        logic [KIND_W-1:0] k;
        // cumulative thresholds: append, remove, read, find, clear, unused kinds
        int          mix[3][6];

        mix[0] = '{55, 65, 80, 93, 95, 100};
        mix[1] = '{20, 52, 70, 90, 93, 100};
        mix[2] = '{35, 55, 75, 94, 97, 100};
        value_pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                       32'h1, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 32'h0000_FFFF};

        error_count  = 0;
        list_len     = 0;
        gap_armed    = 1'b0;
        gap_left     = 0;
        start        = 1'b0;
        kind         = KIND_APPEND;
        position_arg = '0;
        value_arg    = '0;
        rst_n        = 1'b0;

        // directed: empty list, extremes, unused kinds, full list, removal ends
        queue_request(KIND_READ,   5'sd0,   32'sd0, 1'b0, 1'b0);
        queue_request(KIND_REMOVE, -5'sd1,  32'sd0, 1'b0, 1'b0);
        queue_request(KIND_FIND,   5'sd0,   32'sd5, 1'b0, 1'b0);
        queue_request(KIND_APPEND, 5'sd0,   32'h8000_0000, 1'b0, 1'b0);
        queue_request(KIND_APPEND, 5'sd15,  32'h7FFF_FFFF, 1'b0, 1'b0);
        queue_request(KIND_READ,   -5'sd1,  32'sd0, 1'b0, 1'b0);
        queue_request(KIND_READ,   -5'sd2,  32'sd0, 1'b0, 1'b0);
        queue_request(KIND_READ,   -5'sd3,  32'sd0, 1'b0, 1'b0);
        queue_request(KIND_READ,   5'sd2,   32'sd0, 1'b0, 1'b0);
        queue_request(3'd5,        -5'sd16, 32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_request(3'd6,        5'sd15,  32'h0, 1'b0, 1'b0);
        queue_request(3'd7,        -5'sd16, 32'hFFFF_FFFF, 1'b0, 1'b0);
        for (n = 0; n < 14; n++)
            queue_request(KIND_APPEND, 5'sd0, (n % 2) ? 32'hFFFF_FFFF : n, 1'b1, 1'b0);
        queue_request(KIND_APPEND, 5'sd0,   32'sd9, 1'b0, 1'b0);
        queue_request(KIND_READ,   5'sd15,  32'sd0, 1'b0, 1'b0);
        queue_request(KIND_READ,   -5'sd16, 32'sd0, 1'b0, 1'b0);
        queue_request(KIND_FIND,   5'sd0,   32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_request(KIND_FIND,   5'sd0,   32'h7FFF_FFFF, 1'b0, 1'b0);
        queue_request(KIND_REMOVE, 5'sd0,   32'sd0, 1'b0, 1'b0);
        queue_request(KIND_REMOVE, -5'sd1,  32'sd0, 1'b0, 1'b0);
        queue_request(KIND_REMOVE, 5'sd7,   32'sd0, 1'b0, 1'b0);
        queue_request(KIND_FIND,   5'sd0,   32'h1234_5678, 1'b0, 1'b0);
        queue_request(KIND_CLEAR,  5'sd0,   32'sd0, 1'b0, 1'b0);
        queue_request(KIND_FIND,   5'sd0,   32'sd0, 1'b0, 1'b0);

        // random: blocks biased toward filling, draining or a mix
        for (blk = 0; blk < 36; blk++)
        begin
            mode    = $urandom_range(0, 2);
            no_idle = ($urandom_range(0, 3) == 0);
            for (n = 0; n < 40; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < mix[mode][0])
                    k = KIND_APPEND;
                else if (r < mix[mode][1])
                    k = KIND_REMOVE;
                else if (r < mix[mode][2])
                    k = KIND_READ;
                else if (r < mix[mode][3])
                    k = KIND_FIND;
                else if (r < mix[mode][4])
                    k = KIND_CLEAR;
                else
                    k = KIND_W'($urandom_range(5, 7));
                queue_request(k, pick_position(), pick_value(), no_idle,
                              (blk == 0 && n == 0) || ($urandom_range(0, 199) == 0));
            end
        end

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        while (pending_requests.size() != 0 || (start && !req_taken))
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (expected_results.size() != 0)
            report_mismatch("results never returned", VAL_W'(expected_results.size()), '0);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
